/* design/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg
// Types and constants shared by the closed-loop Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package ccr_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int MAX_POINTS_LIMIT   = 1024;
   localparam int ADDR_W             = $clog2(MAX_POINTS_LIMIT);
   localparam int COUNT_W            = 7;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [1:0] ST_LOADED    = 2'd0;
   localparam logic [1:0] ST_EVALUATED = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_EVAL,
      OP_REJECT
   } ccr_op_type;

   typedef struct packed {
      ccr_op_type               op;
      logic [3:0][ADDR_W-1:0]   addr;
      logic signed [31:0]       coord_x;
      logic signed [31:0]       coord_y;
      logic signed [31:0]       coord_z;
      logic [15:0]              frac;
   } ccr_entry_type;

endpackage

/* design/ccr_if.sv */
// ----------------------------------------------------------------------------
// ccr_if
// Request and response channels of the evaluator.
// ----------------------------------------------------------------------------
interface ccr_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [5:0]         point_index;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;
   logic [15:0]        phase;

   modport source (output valid, kind, point_index, coord_x, coord_y, coord_z, phase,
                   input ready);
   modport sink   (input valid, kind, point_index, coord_x, coord_y, coord_z, phase,
                   output ready);
endinterface

interface ccr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] tangent_x;
   logic signed [31:0] tangent_y;
   logic signed [31:0] tangent_z;

   modport source (output valid, status, pos_x, pos_y, pos_z,
                   tangent_x, tangent_y, tangent_z, input ready);
   modport sink   (input valid, status, pos_x, pos_y, pos_z,
                   tangent_x, tangent_y, tangent_z, output ready);
endinterface

/* design/ccr_front.sv */
// ----------------------------------------------------------------------------
// ccr_front
// Accepts requests, holds the point count, classifies each item and works
// out segment, local t and the four wrapped table slots.
// ----------------------------------------------------------------------------
module ccr_front import ccr_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   ccr_req_if.sink             req,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   output logic                push_valid,
   input  logic                push_ready,
   output ccr_entry_type       push_data
);

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [COUNT_W+15:0]   prod;
   logic [COUNT_W-1:0]    seg, idx0, idx2, idx3, seg_nx, idx2_nx;
   logic                  bad_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      count_in  = csr_wr_en ? csr_wr_data : count_ff;
      prod      = (COUNT_W+16)'(req.phase) * (COUNT_W+16)'(count_ff);
      seg       = prod[COUNT_W+15:16];
      seg_nx    = seg + 1'b1;
      idx0      = (seg == '0) ? count_ff - 1'b1 : seg - 1'b1;
      idx2      = (seg_nx == count_ff) ? '0 : seg_nx;
      idx2_nx   = idx2 + 1'b1;
      idx3      = (idx2_nx == count_ff) ? '0 : idx2_nx;
      bad_count = (count_ff == '0) || (32'(count_ff) > MAX_POINTS);

      push_data.coord_x = req.coord_x;
      push_data.coord_y = req.coord_y;
      push_data.coord_z = req.coord_z;
      push_data.frac    = prod[15:0];
      if (req.kind == 1'b0) begin
         push_data.op      = (32'(req.point_index) >= MAX_POINTS) ? OP_REJECT : OP_LOAD;
         push_data.addr[0] = ADDR_W'(req.point_index);
         push_data.addr[1] = '0;
         push_data.addr[2] = '0;
         push_data.addr[3] = '0;
      end else begin
         push_data.op      = bad_count ? OP_REJECT : OP_EVAL;
         push_data.addr[0] = ADDR_W'(idx0);
         push_data.addr[1] = ADDR_W'(seg);
         push_data.addr[2] = ADDR_W'(idx2);
         push_data.addr[3] = ADDR_W'(idx3);
      end
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

/* design/ccr_queue.sv */
// ----------------------------------------------------------------------------
// ccr_queue
// Short FIFO between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module ccr_queue import ccr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  ccr_entry_type push_data,
   output logic          pop_valid,
   input  logic          pop,
   output ccr_entry_type pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ccr_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push;

   always_comb begin
      push   = push_valid && push_ready;
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign push_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ff];

endmodule

/* design/ccr_back.sv */
// ----------------------------------------------------------------------------
// ccr_back
// Point table and the Horner pipeline for position and tangent, with
// rounding, saturation and the response register.
// ----------------------------------------------------------------------------
module ccr_back import ccr_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop,
   input  ccr_entry_type pop_data,
   ccr_rsp_if.source     rsp
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int STAGES = 7;

   function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
      logic signed [31:0] r;
      if (x > 41'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -41'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   logic                 adv;
   logic [STAGES-1:0]    v_ff;
   ccr_op_type           op_ff [STAGES];
   logic signed [16:0]   u_ff  [STAGES];
   logic [95:0]          rd_ff [4];

   logic signed [35:0] a_ff [3];
   logic signed [36:0] b_ff [3], b2_ff [3];
   logic signed [32:0] c_ff [3], c2_ff [3], c3_ff [3], c4_ff [3];
   logic signed [31:0] d_ff [3], d2_ff [3], d3_ff [3], d4_ff [3], d5_ff [3], d6_ff [3];
   logic signed [52:0] m1_ff [3];
   logic signed [53:0] h1_ff [3];
   logic signed [55:0] t1_ff [3];
   logic signed [70:0] m2_ff [3];
   logic signed [72:0] mt_ff [3];
   logic signed [71:0] h2_ff [3];
   logic signed [73:0] tt_ff [3], tt6_ff [3];
   logic signed [88:0] m3_ff [3];

   logic signed [35:0] a_in [3];
   logic signed [36:0] b_in [3];
   logic signed [32:0] c_in [3];
   logic signed [31:0] pt [4][3];
   logic signed [89:0] pos_sum [3];
   logic signed [73:0] tan_sum [3];
   logic signed [31:0] pos_in [3], tan_in [3];
   logic [1:0]         status_in;

   logic               out_v_ff;
   logic [1:0]         status_ff;
   logic signed [31:0] pos_ff [3], tan_ff [3];

   assign adv = !out_v_ff || rsp.ready;
   assign pop = adv && pop_valid;

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [95:0] bank [MAX_POINTS];
      always_ff @(posedge clock) begin
         if (pop && pop_data.op == OP_LOAD) begin
            bank[pop_data.addr[0][IDX_W-1:0]] <=
               {pop_data.coord_z, pop_data.coord_y, pop_data.coord_x};
         end
         if (pop) begin
            rd_ff[k] <= bank[pop_data.addr[k][IDX_W-1:0]];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pt[k][0] = rd_ff[k][31:0];
         pt[k][1] = rd_ff[k][63:32];
         pt[k][2] = rd_ff[k][95:64];
      end
      for (int c = 0; c < 3; c++) begin
         a_in[c] = -36'(pt[0][c]) + 36'(pt[1][c]) * 36'sd3 - 36'(pt[2][c]) * 36'sd3
                   + 36'(pt[3][c]);
         b_in[c] = 37'(pt[0][c]) * 37'sd2 - 37'(pt[1][c]) * 37'sd5
                   + 37'(pt[2][c]) * 37'sd4 - 37'(pt[3][c]);
         c_in[c] = 33'(pt[2][c]) - 33'(pt[0][c]);
         pos_sum[c] = 90'(m3_ff[c]) + (90'(d6_ff[c]) <<< 49) + (90'sd1 <<< 48);
         tan_sum[c] = tt6_ff[c] + (74'sd1 <<< 32);
         pos_in[c]  = sat32(pos_sum[c][89:49]);
         tan_in[c]  = sat32(41'(tan_sum[c][73:33]));
      end
      case (op_ff[STAGES-1])
         OP_LOAD: status_in = ST_LOADED;
         OP_EVAL: status_in = ST_EVALUATED;
         default: status_in = ST_RANGE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[STAGES-2:0], pop_valid};
         out_v_ff <= v_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0] <= pop_data.op;
         u_ff[0]  <= $signed({1'b0, pop_data.frac});
         for (int s = 1; s < STAGES; s++) begin
            op_ff[s] <= op_ff[s-1];
            u_ff[s]  <= u_ff[s-1];
         end
         for (int c = 0; c < 3; c++) begin
            a_ff[c]   <= a_in[c];
            b_ff[c]   <= b_in[c];
            c_ff[c]   <= c_in[c];
            d_ff[c]   <= pt[1][c];
            m1_ff[c]  <= 53'(a_ff[c]) * 53'(u_ff[1]);
            b2_ff[c]  <= b_ff[c];
            c2_ff[c]  <= c_ff[c];
            d2_ff[c]  <= d_ff[c];
            h1_ff[c]  <= 54'(m1_ff[c]) + (54'(b2_ff[c]) <<< 16);
            t1_ff[c]  <= 56'(m1_ff[c]) * 56'sd3 + (56'(b2_ff[c]) <<< 17);
            c3_ff[c]  <= c2_ff[c];
            d3_ff[c]  <= d2_ff[c];
            c4_ff[c]  <= c3_ff[c];
            d4_ff[c]  <= d3_ff[c];
            m2_ff[c]  <= 71'(h1_ff[c]) * 71'(u_ff[3]);
            mt_ff[c]  <= 73'(t1_ff[c]) * 73'(u_ff[3]);
            d5_ff[c]  <= d4_ff[c];
            h2_ff[c]  <= 72'(m2_ff[c]) + (72'(c4_ff[c]) <<< 32);
            tt_ff[c]  <= 74'(mt_ff[c]) + (74'(c4_ff[c]) <<< 32);
            d6_ff[c]  <= d5_ff[c];
            m3_ff[c]  <= 89'(h2_ff[c]) * 89'(u_ff[5]);
            tt6_ff[c] <= tt_ff[c];
         end
         status_ff <= status_in;
         for (int c = 0; c < 3; c++) begin
            pos_ff[c] <= (status_in == ST_EVALUATED) ? pos_in[c] : '0;
            tan_ff[c] <= (status_in == ST_EVALUATED) ? tan_in[c] : '0;
         end
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.status    = status_ff;
   assign rsp.pos_x     = pos_ff[0];
   assign rsp.pos_y     = pos_ff[1];
   assign rsp.pos_z     = pos_ff[2];
   assign rsp.tangent_x = tan_ff[0];
   assign rsp.tangent_y = tan_ff[1];
   assign rsp.tangent_z = tan_ff[2];

endmodule

/* design/closed_catmull_rom_evaluator.sv */
// ----------------------------------------------------------------------------
// closed_catmull_rom_evaluator
// Closed-loop uniform Catmull-Rom position and tangent in Q16.16.
// ----------------------------------------------------------------------------
// Usage: the req_ch channel carries load items (kind 0, write one control
// point into the table) and evaluate items (kind 1, phase in 1/65536 of the
// loop). Every item gives exactly one transfer on rsp_ch, in order: status,
// position and derivative by local t, zeros for loads and rejects.
// csr_wr_en/csr_wr_data set the point count; write it only while idle.
// Throughput: one item per cycle while rsp_ch does not stall, set by the fully
// pipelined back end with four table copies read in parallel.
// Path from request transfer to response valid when the queue is empty:
// queue slot, table read, six arithmetic stages, output register.
// A four-entry queue decouples the front: while rsp_ch stalls the pipeline
// holds and requests are still taken until the queue fills.
// Reset clears the queue, pipeline valids and sets the point count to 4;
// the point table is not cleared, a slot must be loaded before it is read.
// ----------------------------------------------------------------------------
module closed_catmull_rom_evaluator import ccr_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   ccr_req_if.sink            req_ch,
   ccr_rsp_if.source          rsp_ch,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   ccr_entry_type push_data, pop_data;
   logic          push_valid, push_ready, pop_valid, pop;

   ccr_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock, .reset, .req(req_ch), .csr_wr_en, .csr_wr_data,
      .push_valid, .push_ready, .push_data
   );

   ccr_queue u_queue (
      .clock, .reset, .push_valid, .push_ready, .push_data,
      .pop_valid, .pop, .pop_data
   );

   ccr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock, .reset, .pop_valid, .pop, .pop_data, .rsp(rsp_ch)
   );

endmodule

/* design/ccr_checker.sv */
// ----------------------------------------------------------------------------
// ccr_checker
// Port-level checks on the evaluator response channel.
// ----------------------------------------------------------------------------
module ccr_checker import ccr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] pos_x,
   input logic signed [31:0] pos_y,
   input logic signed [31:0] pos_z,
   input logic signed [31:0] tangent_x,
   input logic signed [31:0] tangent_y,
   input logic signed [31:0] tangent_z
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(pos_x))
      else $error("stalled response changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_LOADED || rsp_status == ST_EVALUATED
                    || rsp_status == ST_RANGE)
      else $error("bad status code");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_EVALUATED |->
         pos_x == 0 && pos_y == 0 && pos_z == 0
         && tangent_x == 0 && tangent_y == 0 && tangent_z == 0)
      else $error("non-evaluate transfer with payload");

endmodule

bind closed_catmull_rom_evaluator ccr_checker u_ccr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .pos_x      (rsp_ch.pos_x),
   .pos_y      (rsp_ch.pos_y),
   .pos_z      (rsp_ch.pos_z),
   .tangent_x  (rsp_ch.tangent_x),
   .tangent_y  (rsp_ch.tangent_y),
   .tangent_z  (rsp_ch.tangent_z)
);
